FILE: hw/rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants of the chunky-to-planar writer
// Beat structs, configuration register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int PLANE_COUNT  = 8;
  localparam int MAX_EXTENT   = 2048;
  localparam int OFFSET_W     = 20;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int BPR_RESET    = 80;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_BYTES_PER_ROW = 3'd4,
    REG_LONG_MODE     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] pixels_left;
    logic [31:0] pixels_right;
  } in_beat_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [31:0]         plane0_word;
    logic [31:0]         plane1_word;
    logic [31:0]         plane2_word;
    logic [31:0]         plane3_word;
    logic [31:0]         plane4_word;
    logic [31:0]         plane5_word;
    logic [31:0]         plane6_word;
    logic [31:0]         plane7_word;
    logic                store_is_long;
    logic                rect_done;
  } out_beat_t;

  typedef logic [PLANE_COUNT-1:0][7:0] plane_bytes_t;

  typedef struct packed {
    logic [10:0]         dest_x;
    logic [10:0]         dest_y;
    logic [11:0]         rect_width;
    logic [11:0]         rect_height;
    logic [8:0]          bytes_per_row;
    logic                long_store_mode;
    logic [OFFSET_W-1:0] start_offset;
  } cfg_t;

  typedef struct packed {
    logic                restart;
    logic [OFFSET_W-1:0] start_offset;
  } cfg_wr_t;

endpackage

FILE: hw/rtl/c2p_cfg_regs.sv
// ----------------------------------------------------------------------------
// c2p_cfg_regs: configuration register file
// Holds the rectangle setup and the offset of its top-left store.
// ----------------------------------------------------------------------------
module c2p_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [c2p_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [c2p_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output c2p_pkg::cfg_t                       cfg,
  output c2p_pkg::cfg_wr_t                    cfg_wr
);
  import c2p_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic hit;
  logic [OFFSET_W-1:0] prod;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (cfg_we) begin
      hit = 1'b1;
      unique case (cfg_reg_t'(cfg_addr))
        REG_DEST_X:        cfg_nxt.dest_x          = cfg_wdata[10:0];
        REG_DEST_Y:        cfg_nxt.dest_y          = cfg_wdata[10:0];
        REG_RECT_WIDTH:    cfg_nxt.rect_width      = cfg_wdata[11:0];
        REG_RECT_HEIGHT:   cfg_nxt.rect_height     = cfg_wdata[11:0];
        REG_BYTES_PER_ROW: cfg_nxt.bytes_per_row   = cfg_wdata[8:0];
        REG_LONG_MODE:     cfg_nxt.long_store_mode = cfg_wdata[0];
        default:           hit = 1'b0;
      endcase
    end
    // top-left store: dest_y * stride + dest_x / 8
    prod = OFFSET_W'(20'(cfg_nxt.dest_y) * 20'(cfg_nxt.bytes_per_row));
    cfg_nxt.start_offset = prod + OFFSET_W'(cfg_nxt.dest_x[10:3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{bytes_per_row: 9'(BPR_RESET), default: '0};
    end else if (hit) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg                 = cfg_r;
  assign cfg_wr.restart      = hit;
  assign cfg_wr.start_offset = cfg_nxt.start_offset;

endmodule

FILE: hw/rtl/c2p_transpose.sv
// ----------------------------------------------------------------------------
// c2p_transpose: 8x8 bit-matrix transpose
// Turns eight chunky pixels into one byte per bitplane, pixel 0 in bit 7.
// ----------------------------------------------------------------------------
module c2p_transpose (
  input  c2p_pkg::in_beat_t     pix,
  output c2p_pkg::plane_bytes_t planes
);
  import c2p_pkg::*;

  logic [7:0][7:0] px;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i]     = pix.pixels_left[31-8*i -: 8];
      px[i + 4] = pix.pixels_right[31-8*i -: 8];
    end
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int i = 0; i < 8; i++) begin
        planes[p][7-i] = px[i][p];
      end
    end
  end

endmodule

FILE: hw/rtl/c2p_sequencer.sv
// ----------------------------------------------------------------------------
// c2p_sequencer: rectangle walk and long-store gather
// Tracks row, group and offset, gathers groups in long mode, builds stores.
// ----------------------------------------------------------------------------
module c2p_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  c2p_pkg::cfg_t         cfg,
  input  c2p_pkg::cfg_wr_t      cfg_wr,
  input  logic                  step,
  input  c2p_pkg::plane_bytes_t planes,
  output logic                  res_valid,
  output c2p_pkg::out_beat_t    res
);
  import c2p_pkg::*;

  logic [11:0]             row_count_r, row_count_nxt;
  logic [8:0]              group_count_r, group_count_nxt;
  logic [OFFSET_W-1:0]     cur_offset_r, cur_offset_nxt;
  logic [OFFSET_W-1:0]     row_base_r, row_base_nxt;
  logic [1:0]              gather_count_r, gather_count_nxt;
  logic [PLANE_COUNT-1:0][23:0] gather_r, gather_nxt;

  logic [11:0] w_eff, h_eff;
  logic [8:0]  per_row;
  logic        empty;
  logic [8:0]  group_inc;
  logic [11:0] row_inc;
  logic        row_end, last_row;
  logic        emit;
  logic [OFFSET_W-1:0] next_row_base;
  logic [PLANE_COUNT-1:0][31:0] words;

  always_comb begin
    w_eff = (cfg.rect_width  > 12'(MAX_EXTENT)) ? 12'(MAX_EXTENT) : cfg.rect_width;
    h_eff = (cfg.rect_height > 12'(MAX_EXTENT)) ? 12'(MAX_EXTENT) : cfg.rect_height;
    empty = (w_eff == 12'd0) || (h_eff == 12'd0);
    if (cfg.long_store_mode) begin
      per_row = {7'((13'(w_eff) + 13'd31) >> 5), 2'b00};
    end else begin
      per_row = 9'((13'(w_eff) + 13'd7) >> 3);
    end
    group_inc     = group_count_r + 9'd1;
    row_inc       = row_count_r + 12'd1;
    row_end       = group_inc >= per_row;
    last_row      = row_inc >= h_eff;
    next_row_base = row_base_r + OFFSET_W'(cfg.bytes_per_row);
    emit          = step && !empty &&
                    (!cfg.long_store_mode || (gather_count_r == 2'd3));
  end

  always_comb begin
    row_count_nxt    = row_count_r;
    group_count_nxt  = group_count_r;
    cur_offset_nxt   = cur_offset_r;
    row_base_nxt     = row_base_r;
    gather_count_nxt = gather_count_r;
    gather_nxt       = gather_r;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (cfg.long_store_mode) begin
        words[p] = {gather_r[p], planes[p]};
      end else begin
        words[p] = {24'd0, planes[p]};
      end
    end
    if (cfg_wr.restart) begin
      row_count_nxt    = '0;
      group_count_nxt  = '0;
      gather_count_nxt = '0;
      cur_offset_nxt   = cfg_wr.start_offset;
      row_base_nxt     = cfg_wr.start_offset;
    end else if (step && !empty) begin
      if (!emit) begin
        // gather one more group, oldest byte moves up
        for (int p = 0; p < PLANE_COUNT; p++) begin
          gather_nxt[p] = {gather_r[p][15:0], planes[p]};
        end
        gather_count_nxt = gather_count_r + 2'd1;
        group_count_nxt  = group_inc;
      end else begin
        gather_count_nxt = '0;
        if (row_end) begin
          group_count_nxt = '0;
          if (last_row) begin
            row_count_nxt  = '0;
            cur_offset_nxt = cfg.start_offset;
            row_base_nxt   = cfg.start_offset;
          end else begin
            row_count_nxt  = row_inc;
            cur_offset_nxt = next_row_base;
            row_base_nxt   = next_row_base;
          end
        end else begin
          group_count_nxt = group_inc;
          cur_offset_nxt  = cur_offset_r +
                            (cfg.long_store_mode ? OFFSET_W'(4) : OFFSET_W'(1));
        end
      end
    end
  end

  always_comb begin
    res_valid         = emit;
    res.byte_offset   = cur_offset_r;
    res.plane0_word   = words[0];
    res.plane1_word   = words[1];
    res.plane2_word   = words[2];
    res.plane3_word   = words[3];
    res.plane4_word   = words[4];
    res.plane5_word   = words[5];
    res.plane6_word   = words[6];
    res.plane7_word   = words[7];
    res.store_is_long = cfg.long_store_mode;
    res.rect_done     = row_end && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      group_count_r  <= '0;
      cur_offset_r   <= '0;
      row_base_r     <= '0;
      gather_count_r <= '0;
    end else begin
      row_count_r    <= row_count_nxt;
      group_count_r  <= group_count_nxt;
      cur_offset_r   <= cur_offset_nxt;
      row_base_r     <= row_base_nxt;
      gather_count_r <= gather_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gather_r <= gather_nxt;
  end

  a_long_after_gather: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.store_is_long |-> gather_count_r == 2'd3)
    else $error("long store before four groups were gathered");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (row_count_r < h_eff) && (group_count_r < per_row))
    else $error("rectangle walk left the rectangle");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.rect_done |=> (row_count_r == 12'd0) && (group_count_r == 9'd0))
    else $error("walk did not restart after the last store");

  a_empty_silent: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !res_valid)
    else $error("store produced for an empty rectangle");

endmodule

FILE: hw/rtl/chunky_to_planar_rect_writer_top.sv
// ----------------------------------------------------------------------------
// chunky_to_planar_rect_writer_top: chunky-to-planar rectangle writer
// Transposes 8-pixel groups into bitplane stores walking a rectangle.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat is held in the input register; its store
//   is loaded into the result register when that register is free or drained.
// Throughput: one input beat per cycle while the result channel does not stall;
//   the transpose and counter update sit in a single pass between the input and result registers.
// Reset: synchronous active-low rst_n clears both pipeline stages and the
//   rectangle walk; configuration registers return to zero, bytes_per_row to 80.
module chunky_to_planar_rect_writer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel: one beat is one group of eight chunky pixels
  input  logic                             in_valid,
  output logic                             in_ready,
  input  c2p_pkg::in_beat_t                in_data,
  // result channel: one beat is one bitplane store
  output logic                             out_valid,
  input  logic                             out_ready,
  output c2p_pkg::out_beat_t               out_data,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [c2p_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [c2p_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import c2p_pkg::*;

  logic         in_valid_r;
  in_beat_t     in_data_r;
  logic         out_valid_r;
  out_beat_t    out_data_r;
  logic         advance;

  cfg_t         cfg;
  cfg_wr_t      cfg_wr;
  plane_bytes_t planes;
  logic         res_valid;
  out_beat_t    res;

  // Move the held beat forward whenever the result register is free or
  // being drained this cycle; a beat that makes no store still advances.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  // Take a new beat when the input register is empty or emptying.
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload register: capture only on an accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  c2p_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr)
  );

  c2p_transpose u_transpose (
    .pix    (in_data_r),
    .planes (planes)
  );

  c2p_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .step      (advance),
    .planes    (planes),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on advance, drop the beat once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/c2p_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c2p_store_checker: store predictor and comparator for the c2p writer
// Tracks register writes and accepted pixel beats to predict every bitplane
// store, then compares each store beat with the oldest prediction.
// ----------------------------------------------------------------------------
module c2p_store_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  c2p_pkg::in_beat_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  c2p_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [c2p_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [c2p_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatch_count,
  output int unsigned                    stores_pending,
  output int unsigned                    stores_checked,
  output int unsigned                    rects_closed
);
  import c2p_pkg::*;

  localparam int REPORT_LIMIT = 25;

  // shadow registers
  logic [10:0] left_col;
  logic [10:0] top_row;
  logic [11:0] width_px;
  logic [11:0] height_rows;
  logic [8:0]  row_stride;
  logic        long_mode;

  // rectangle walk
  logic [11:0]        row_idx;
  int unsigned        group_idx;
  logic [OFFSET_W-1:0] next_offset;
  int unsigned        gathered;
  logic [23:0]        gather_buf [PLANE_COUNT];

  out_beat_t   store_q [$];
  int unsigned errs = 0, checked = 0, closed = 0;

  function automatic int unsigned clip_extent(logic [11:0] v);
    return (v > MAX_EXTENT) ? MAX_EXTENT : int'(v);
  endfunction

  function automatic logic [OFFSET_W-1:0] offset_of_row(logic [11:0] row);
    logic [31:0] full;
    full = (32'(top_row) + 32'(row)) * 32'(row_stride) + 32'(left_col >> 3);
    return full[OFFSET_W-1:0];
  endfunction

  function automatic void restart_walk();
    row_idx   = '0;
    group_idx = 0;
    gathered  = 0;
    for (int p = 0; p < PLANE_COUNT; p++) gather_buf[p] = '0;
    next_offset = offset_of_row('0);
  endfunction

  // plane p byte: bit 7-i is bit p of pixel i
  function automatic plane_bytes_t transpose_group(in_beat_t b);
    logic [63:0]  px;
    plane_bytes_t t;
    px = {b.pixels_left, b.pixels_right};
    for (int i = 0; i < 8; i++)
      for (int p = 0; p < PLANE_COUNT; p++) t[p][7-i] = px[56 - 8*i + p];
    return t;
  endfunction

  // step to the next row; returns 1 when the rectangle just completed
  function automatic bit close_row();
    group_idx = 0;
    row_idx   = row_idx + 12'd1;
    if (row_idx >= clip_extent(height_rows)) begin
      restart_walk();
      return 1'b1;
    end
    next_offset = offset_of_row(row_idx);
    return 1'b0;
  endfunction

  function automatic out_beat_t build_store(logic [OFFSET_W-1:0] off,
                                            logic [7:0][31:0] words,
                                            logic is_long, logic last);
    out_beat_t s;
    s.byte_offset   = off;
    s.plane0_word   = words[0];
    s.plane1_word   = words[1];
    s.plane2_word   = words[2];
    s.plane3_word   = words[3];
    s.plane4_word   = words[4];
    s.plane5_word   = words[5];
    s.plane6_word   = words[6];
    s.plane7_word   = words[7];
    s.store_is_long = is_long;
    s.rect_done     = last;
    return s;
  endfunction

  function automatic logic [7:0][31:0] plane_words(out_beat_t s);
    return {s.plane7_word, s.plane6_word, s.plane5_word, s.plane4_word,
            s.plane3_word, s.plane2_word, s.plane1_word, s.plane0_word};
  endfunction

  function automatic void apply_write(logic [CFG_ADDR_W-1:0] addr,
                                      logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(addr))
      REG_DEST_X:        left_col    = data[10:0];
      REG_DEST_Y:        top_row     = data[10:0];
      REG_RECT_WIDTH:    width_px    = data[11:0];
      REG_RECT_HEIGHT:   height_rows = data[11:0];
      REG_BYTES_PER_ROW: row_stride  = data[8:0];
      REG_LONG_MODE:     long_mode   = data[0];
      default:           return;
    endcase
    restart_walk();
  endfunction

  function automatic void predict_group(in_beat_t b);
    int unsigned         w, h, per_row;
    plane_bytes_t        bytes;
    logic [7:0][31:0]    words;
    logic [OFFSET_W-1:0] off;
    logic                last;
    w = clip_extent(width_px);
    h = clip_extent(height_rows);
    if (w == 0 || h == 0) return;
    bytes = transpose_group(b);
    group_idx++;
    if (!long_mode) begin
      per_row = (w + 7) / 8;
      for (int p = 0; p < PLANE_COUNT; p++) words[p] = {24'h0, bytes[p]};
      off = next_offset;
      if (group_idx >= per_row) last = close_row();
      else begin
        last = 1'b0;
        next_offset = next_offset + 20'd1;
      end
      store_q.push_back(build_store(off, words, 1'b0, last));
      return;
    end
    per_row = ((w + 31) / 32) * 4;
    if (gathered < 3) begin
      for (int p = 0; p < PLANE_COUNT; p++)
        gather_buf[p] = {gather_buf[p][15:0], bytes[p]};
      gathered++;
      return;
    end
    for (int p = 0; p < PLANE_COUNT; p++) begin
      words[p]      = {gather_buf[p], bytes[p]};
      gather_buf[p] = '0;
    end
    gathered = 0;
    off = next_offset;
    if (group_idx >= per_row) last = close_row();
    else begin
      last = 1'b0;
      next_offset = next_offset + 20'd4;
    end
    store_q.push_back(build_store(off, words, 1'b1, last));
  endfunction

  function automatic void check_store(out_beat_t got);
    out_beat_t        want;
    logic [7:0][31:0] gw, ww;
    bit               bad;
    if (store_q.size() == 0) begin
      if (errs < REPORT_LIMIT)
        $display("%0t ns: store beat expected none, got offset %h", $time, got.byte_offset);
      errs++;
      return;
    end
    want = store_q.pop_front();
    gw   = plane_words(got);
    ww   = plane_words(want);
    bad  = 1'b0;
    checked++;
    if (want.rect_done) closed++;
    if (got.byte_offset !== want.byte_offset) begin
      bad = 1'b1;
      if (errs < REPORT_LIMIT)
        $display("%0t ns: byte_offset expected %h got %h",
                 $time, want.byte_offset, got.byte_offset);
    end
    for (int p = 0; p < PLANE_COUNT; p++)
      if (gw[p] !== ww[p]) begin
        bad = 1'b1;
        if (errs < REPORT_LIMIT)
          $display("%0t ns: plane%0d_word expected %h got %h", $time, p, ww[p], gw[p]);
      end
    if (got.store_is_long !== want.store_is_long) begin
      bad = 1'b1;
      if (errs < REPORT_LIMIT)
        $display("%0t ns: store_is_long expected %b got %b",
                 $time, want.store_is_long, got.store_is_long);
    end
    if (got.rect_done !== want.rect_done) begin
      bad = 1'b1;
      if (errs < REPORT_LIMIT)
        $display("%0t ns: rect_done expected %b got %b",
                 $time, want.rect_done, got.rect_done);
    end
    if (bad) errs++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      left_col    = '0;
      top_row     = '0;
      width_px    = '0;
      height_rows = '0;
      row_stride  = 9'(BPR_RESET);
      long_mode   = 1'b0;
      restart_walk();
      store_q.delete();
    end else begin
      if (cfg_we) apply_write(cfg_addr, cfg_wdata);
      if (in_valid && in_ready) predict_group(in_data);
      if (out_valid && out_ready) check_store(out_data);
    end
    mismatch_count <= errs;
    stores_pending <= store_q.size();
    stores_checked <= checked;
    rects_closed   <= closed;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the chunky-to-planar rectangle writer
// Programs a series of rectangles (byte and gathered 32-bit stores, empty,
// oversized, ragged and wrapping ones), feeds pixel groups through them with
// random idle gaps on both channels, and lets the store checker judge every
// result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import c2p_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int CHOKE_CYCLES = 300;
  localparam int DRAIN_PAUSE  = 6;    // covers the two-stage pipeline

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatch_count, stores_pending, stores_checked, rects_closed;

  // stimulus bookkeeping
  int unsigned groups_fed;       // groups fed into a non-empty rectangle
  int unsigned setups_done;
  int unsigned eff_w, eff_h;
  bit          eff_long;
  bit          feed_calm, drain_calm;
  int unsigned holds_asked, holds_done;

  chunky_to_planar_rect_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  c2p_store_checker store_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .stores_pending (stores_pending),
    .stores_checked (stores_checked),
    .rects_closed   (rects_closed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  // A calm side never idles.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 48);
  endfunction

  function automatic in_beat_t random_group();
    in_beat_t    b;
    int unsigned r;
    r = $urandom_range(0, 9);
    b.pixels_left  = $urandom;
    b.pixels_right = $urandom;
    if (r == 0) b = '0;
    else if (r == 1) b = '1;
    return b;
  endfunction

  // Drive one register write; the caller drops the write enable after the
  // last one so the enable never gets two assignments in one step.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program a whole rectangle; every register write restarts the walk.
  task automatic program_rect(logic [11:0] x, logic [11:0] y, logic [11:0] w,
                              logic [11:0] h, logic [11:0] bpr, logic [11:0] mode);
    write_reg(REG_DEST_X,        x);
    write_reg(REG_DEST_Y,        y);
    write_reg(REG_RECT_WIDTH,    w);
    write_reg(REG_RECT_HEIGHT,   h);
    write_reg(REG_BYTES_PER_ROW, bpr);
    write_reg(REG_LONG_MODE,     mode);
    cfg_we   <= 1'b0;
    eff_w    = (w > MAX_EXTENT) ? MAX_EXTENT : int'(w);
    eff_h    = (h > MAX_EXTENT) ? MAX_EXTENT : int'(h);
    eff_long = mode[0];
    setups_done++;
  endtask

  // Offer one beat after a random gap; hold valid and payload until taken.
  task automatic push_group(in_beat_t b);
    int unsigned gap;
    gap = pick_gap(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (eff_w != 0 && eff_h != 0) groups_fed++;
  endtask

  // Drop valid, wait for every predicted store, then let any group that
  // only filled the gather buffer clear the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stores_pending != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // One randomly shaped rectangle, fed one to two times over plus a stray
  // partial pass so the next setup lands mid-walk.
  task automatic random_phase();
    logic [11:0] x, y, w, h, bpr, mode;
    int unsigned r, per_row, n;
    mode = {11'($urandom), 1'($urandom_range(0, 1))};
    r = $urandom_range(0, 99);
    if (r < 8) w = 12'd0;
    else if (r < 60) w = 12'($urandom_range(1, 64));
    else if (r < 90) w = 12'($urandom_range(1, 4) * (mode[0] ? 32 : 8));
    else w = 12'($urandom_range(65, 300));
    h = ($urandom_range(0, 99) < 8) ? 12'd0 : 12'($urandom_range(1, 5));
    x = 12'($urandom_range(0, 4095));
    y = 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 9);
    case (r)
      0:       bpr = 12'd0;
      1:       bpr = 12'd1;
      2:       bpr = 12'd256;
      3:       bpr = 12'd511;
      default: bpr = 12'($urandom_range(1, 511));
    endcase
    bpr[11:9]  = 3'($urandom);
    feed_calm  = ($urandom_range(0, 3) == 0);
    drain_calm = ($urandom_range(0, 3) == 0);
    program_rect(x, y, w, h, bpr, mode);
    if (eff_w == 0 || eff_h == 0) n = $urandom_range(1, 4);
    else begin
      per_row = eff_long ? ((eff_w + 31) / 32) * 4 : (eff_w + 7) / 8;
      n = per_row * eff_h * $urandom_range(1, 2) + $urandom_range(0, 5);
      if (n > 200) n = 200;
    end
    repeat (n) push_group(random_group());
    settle();
  endtask

  // Receiver: random stalls, calm stretches, and on request one long
  // hold-off so the block backs up into its input.
  initial begin
    int unsigned stall, run;
    out_ready = 1'b0;
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap(drain_calm);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = $urandom_range(1, 16);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_addr    = REG_DEST_X;
    cfg_wdata   = '0;
    groups_fed  = 0;
    setups_done = 0;
    eff_w       = 0;
    eff_h       = 0;
    eff_long    = 1'b0;
    feed_calm   = 1'b0;
    drain_calm  = 1'b0;
    holds_asked = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Reset leaves an empty rectangle: these groups must vanish.
    push_group('{pixels_left: 32'h12345678, pixels_right: 32'h9abcdef0});
    push_group('{pixels_left: 32'hffffffff, pixels_right: 32'h00000000});
    settle();

    // Small byte-mode rectangle with pixel extremes and both diagonals.
    program_rect(12'd0, 12'd0, 12'd16, 12'd2, 12'd80, 12'd0);
    push_group('{pixels_left: 32'h00000000, pixels_right: 32'h00000000});
    push_group('{pixels_left: 32'hffffffff, pixels_right: 32'hffffffff});
    push_group('{pixels_left: 32'h01020408, pixels_right: 32'h10204080});
    push_group('{pixels_left: 32'h80402010, pixels_right: 32'h08040201});
    settle();

    // Far corner with the widest stride: offsets run past 2^20 and wrap.
    program_rect(12'd2047, 12'd2047, 12'd8, 12'd8, 12'd511, 12'd0);
    push_group('{pixels_left: 32'haa55aa55, pixels_right: 32'h55aa55aa});
    repeat (7) push_group(random_group());
    settle();

    // Gathered stores on a ragged width (40 px -> eight groups per row),
    // then two extra groups that restart the walk and sit in the gather
    // buffer until the next setup clears them.
    program_rect(12'd8, 12'd3, 12'd40, 12'd1, 12'd256, 12'd1);
    push_group('{pixels_left: 32'hffffffff, pixels_right: 32'hffffffff});
    push_group('{pixels_left: 32'h00000000, pixels_right: 32'h00000000});
    repeat (8) push_group(random_group());
    settle();

    // Zero height: ignored like zero width.
    program_rect(12'd0, 12'd0, 12'd8, 12'd0, 12'd80, 12'd0);
    push_group(random_group());
    settle();

    // --- random part ---
    // Oversized extents: clamp to 2048, one full byte-mode row plus a bit.
    feed_calm  = 1'b0;
    drain_calm = 1'b0;
    program_rect(12'd0, 12'd5, 12'd4095, 12'd4095, 12'd1, 12'd0);
    repeat (260) push_group(random_group());
    settle();

    // Full-width gathered row: 256 groups close the rectangle, then restart.
    program_rect(12'd2047, 12'd0, 12'd2048, 12'd1, 12'd256, 12'd1);
    repeat (260) push_group(random_group());
    settle();

    // Back-pressure: the receiver holds off while the sender streams.
    feed_calm = 1'b1;
    program_rect(12'd0, 12'd0, 12'd64, 12'd4, 12'd80, 12'd0);
    holds_asked++;
    repeat (120) push_group(random_group());
    settle();

    while (groups_fed < ITEM_TARGET) random_phase();

    // settle() has already waited out every store and the pipeline tail
    $display("Covered %0d pixel groups over %0d rectangle setups (byte and gathered stores).",
             groups_fed, setups_done);
    $display("Compared %0d plane stores, %0d rectangles closed.",
             stores_checked, rects_closed);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: %0d stores still pending", stores_pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
